FILE: rtl/core/ttm_pkg.sv
// ----------------------------------------------------------------------------
// ttm_pkg
// Shared constants and types of the transaction tag round-trip matcher.
// ----------------------------------------------------------------------------
package ttm_pkg;

  localparam int NUM_ENTRIES = 256;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int TAG_W       = 96;
  localparam int TIME_W      = 32;
  localparam int LIMIT_W     = 16;

  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(NUM_ENTRIES - 1);
  localparam logic [9:0]         MIN_PKT_LEN = 10'd20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_RESP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef struct packed {
    logic              arm_we;
    logic [IDX_W-1:0]  arm_addr;
    logic [TAG_W-1:0]  arm_tag;
    logic [TIME_W-1:0] arm_time;
    logic              ans_we;
    logic [IDX_W-1:0]  ans_addr;
    logic [TIME_W-1:0] ans_rtt;
    logic [IDX_W-1:0]  tag_raddr;
    logic [IDX_W-1:0]  rtt_raddr;
  } ttm_store_cmd_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] sent_ms;
    logic              pend;
    logic [TIME_W-1:0] rtt;
    logic              answered;
  } ttm_store_rsp_t;

  typedef struct packed {
    logic              matched;
    logic [7:0]        match_index;
    logic [TIME_W-1:0] rtt_ms;
    logic              rtt_valid;
  } ttm_result_t;

endpackage

FILE: rtl/core/ttm_ifs.sv
// ----------------------------------------------------------------------------
// ttm channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface ttm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  entry_index;
  logic [31:0] tag_high;
  logic [63:0] tag_low;
  logic [9:0]  packet_length;
  logic [31:0] now_ms;

  modport source (output valid, opcode, entry_index, tag_high, tag_low,
                  packet_length, now_ms, input ready);
  modport sink   (input valid, opcode, entry_index, tag_high, tag_low,
                  packet_length, now_ms, output ready);
endinterface

interface ttm_out_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [7:0]  match_index;
  logic [31:0] rtt_ms;
  logic        rtt_valid;

  modport source (output valid, matched, match_index, rtt_ms, rtt_valid,
                  input ready);
  modport sink   (input valid, matched, match_index, rtt_ms, rtt_valid,
                  output ready);
endinterface

FILE: rtl/core/ttm_entry_store.sv
// ----------------------------------------------------------------------------
// ttm_entry_store
// Entry table: tag/send-time memory, rtt memory and per-entry status bits.
// ----------------------------------------------------------------------------
module ttm_entry_store
  import ttm_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  ttm_store_cmd_t cmd,
  output ttm_store_rsp_t rsp
);

  logic [TAG_W+TIME_W-1:0] tag_mem [NUM_ENTRIES];
  logic [TIME_W-1:0]       rtt_mem [NUM_ENTRIES];

  logic [NUM_ENTRIES-1:0]  armed_r;
  logic [NUM_ENTRIES-1:0]  answered_r;

  logic [TAG_W+TIME_W-1:0] tag_q_r;
  logic [TIME_W-1:0]       rtt_q_r;
  logic                    pend_q_r;
  logic                    ans_q_r;

  always_ff @(posedge clk) begin
    if (cmd.arm_we) begin
      tag_mem[cmd.arm_addr] <= {cmd.arm_tag, cmd.arm_time};
    end
    tag_q_r <= tag_mem[cmd.tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ans_we) begin
      rtt_mem[cmd.ans_addr] <= cmd.ans_rtt;
    end
    rtt_q_r <= rtt_mem[cmd.rtt_raddr];
  end

  // status bits travel with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= '0;
      answered_r <= '0;
      pend_q_r   <= 1'b0;
      ans_q_r    <= 1'b0;
    end else begin
      if (cmd.arm_we) begin
        armed_r[cmd.arm_addr]    <= 1'b1;
        answered_r[cmd.arm_addr] <= 1'b0;
      end
      if (cmd.ans_we) begin
        answered_r[cmd.ans_addr] <= 1'b1;
      end
      pend_q_r <= armed_r[cmd.tag_raddr] & ~answered_r[cmd.tag_raddr];
      ans_q_r  <= answered_r[cmd.rtt_raddr];
    end
  end

  assign rsp.tag       = tag_q_r[TAG_W+TIME_W-1:TIME_W];
  assign rsp.sent_ms   = tag_q_r[TIME_W-1:0];
  assign rsp.pend      = pend_q_r;
  assign rsp.rtt       = rtt_q_r;
  assign rsp.answered  = ans_q_r;

endmodule

FILE: rtl/core/transaction_tag_rtt_matcher.sv
// ----------------------------------------------------------------------------
// transaction_tag_rtt_matcher
// Matches response tags against a table of armed request entries and
// records round-trip times.
// ----------------------------------------------------------------------------
// One item at a time. Arm, ignored and runt response items go from idle to
// the output state, a read through the read state. A response of at least
// MIN_PKT_LEN checks one stored tag per cycle through the tag memory read
// port until a match or the last entry; the result is shown until taken.
// Synchronous active-low reset clears entry status bits and control state
// and sets the time limit to 100; tag and time memories are not cleared.
module transaction_tag_rtt_matcher
  import ttm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  ttm_in_if.sink             in_ch,
  ttm_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r;

  logic [7:0]         idx_r, idx_nxt;
  logic               inrange_r, inrange_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               chk_live_r, chk_live_nxt;
  ttm_result_t        res_r, res_nxt;

  logic               out_valid_r, out_valid_nxt;
  ttm_result_t        out_r, out_nxt;

  ttm_store_cmd_t     cmd;
  ttm_store_rsp_t     rsp;

  logic               accept;
  logic               in_range;
  logic               hit;
  logic [TIME_W-1:0]  rtt_calc;

  ttm_entry_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = ({24'd0, in_ch.entry_index} < 32'(NUM_ENTRIES));
  assign hit         = chk_live_r && rsp.pend && (rsp.tag == tag_r);
  assign rtt_calc    = now_r - rsp.sent_ms;

  always_comb begin
    cmd           = '0;
    cmd.arm_addr  = IDX_W'(in_ch.entry_index);
    cmd.arm_tag   = {in_ch.tag_high, in_ch.tag_low};
    cmd.arm_time  = in_ch.now_ms;
    cmd.arm_we    = accept && (in_ch.opcode == OP_ARM) && in_range;
    cmd.ans_addr  = chk_idx_r;
    cmd.ans_rtt   = rtt_calc;
    cmd.ans_we    = (state_r == S_SCAN) && hit;
    cmd.tag_raddr = scan_r;
    cmd.rtt_raddr = IDX_W'(in_ch.entry_index);
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    inrange_nxt   = inrange_r;
    tag_nxt       = tag_r;
    now_nxt       = now_r;
    scan_nxt      = scan_r;
    chk_idx_nxt   = chk_idx_r;
    chk_live_nxt  = chk_live_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt      = in_ch.entry_index;
          inrange_nxt  = in_range;
          tag_nxt      = {in_ch.tag_high, in_ch.tag_low};
          now_nxt      = in_ch.now_ms;
          scan_nxt     = '0;
          chk_live_nxt = 1'b0;
          res_nxt      = '0;
          state_nxt    = S_OUT;
          if (in_ch.opcode == OP_RESP && in_ch.packet_length >= MIN_PKT_LEN) begin
            state_nxt = S_SCAN;
          end else if (in_ch.opcode == OP_READ) begin
            state_nxt = S_RD;
          end
        end
      end
      S_SCAN: begin
        // read of scan_r issued now, its data is checked next cycle
        chk_idx_nxt  = scan_r;
        chk_live_nxt = 1'b1;
        scan_nxt     = scan_r + 1'b1;
        if (hit) begin
          res_nxt.matched     = 1'b1;
          res_nxt.match_index = 8'(chk_idx_r);
          res_nxt.rtt_ms      = rtt_calc;
          res_nxt.rtt_valid   = 1'b1;
          state_nxt           = S_OUT;
        end else if (chk_live_r && chk_idx_r == LAST_IDX) begin
          state_nxt = S_OUT;
        end
      end
      S_RD: begin
        res_nxt.match_index = idx_r;
        if (inrange_r && rsp.answered) begin
          res_nxt.rtt_ms    = rsp.rtt;
          res_nxt.rtt_valid = (rsp.rtt < {16'd0, limit_r});
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      chk_live_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chk_live_r  <= chk_live_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    inrange_r <= inrange_nxt;
    tag_r     <= tag_nxt;
    now_r     <= now_nxt;
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.matched     = out_r.matched;
  assign out_ch.match_index = out_r.match_index;
  assign out_ch.rtt_ms      = out_r.rtt_ms;
  assign out_ch.rtt_valid   = out_r.rtt_valid;

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result shown without passing the output state");

  a_match_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.matched |-> out_r.rtt_valid)
    else $error("matched result without rtt_valid");

  a_scan_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && chk_live_r |-> chk_idx_r == scan_r - 1'b1)
    else $error("checked entry out of step with issued read");

  a_no_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.arm_we && cmd.ans_we))
    else $error("arm and answer writes in the same cycle");

endmodule

FILE: verif/rtt_match_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_match_monitor
// Watches the request and result channels of the tag matcher, keeps its own
// copy of the entry table and time limit, predicts one result per accepted
// request item and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module rtt_match_monitor
  import ttm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  ttm_in_if                  in_ch,
  ttm_out_if                 out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output int unsigned        fail_count,
  output int unsigned        owed,
  output int unsigned        match_count,
  output int unsigned        good_read_count
);

  logic [LIMIT_W-1:0] limit_ms;
  bit                 armed    [NUM_ENTRIES];
  bit                 answered [NUM_ENTRIES];
  logic [TAG_W-1:0]   tag_of   [NUM_ENTRIES];
  logic [TIME_W-1:0]  sent_at  [NUM_ENTRIES];
  logic [TIME_W-1:0]  rtt_of   [NUM_ENTRIES];

  ttm_result_t expected_results[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 100)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // updates the entry table and returns the result the item must produce
  function automatic ttm_result_t predict_rtt(input logic [1:0] op,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [TAG_W-1:0] tag,
                                              input logic [9:0] len,
                                              input logic [TIME_W-1:0] now);
    ttm_result_t r;
    bit found;
    r = '0;
    found = 1'b0;
    case (op)
      OP_ARM: begin
        tag_of[idx]   = tag;
        sent_at[idx]  = now;
        armed[idx]    = 1'b1;
        answered[idx] = 1'b0;
      end
      OP_RESP: begin
        if (len >= MIN_PKT_LEN) begin
          // lowest pending index wins
          for (int k = 0; k < NUM_ENTRIES; k++) begin
            if (!found && armed[k] && !answered[k] && tag_of[k] == tag) begin
              found         = 1'b1;
              rtt_of[k]     = now - sent_at[k];
              answered[k]   = 1'b1;
              r.matched     = 1'b1;
              r.match_index = 8'(k);
              r.rtt_ms      = rtt_of[k];
              r.rtt_valid   = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        r.match_index = 8'(idx);
        if (answered[idx]) begin
          r.rtt_ms    = rtt_of[idx];
          r.rtt_valid = (rtt_of[idx] < TIME_W'(limit_ms));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    ttm_result_t want;
    if (!rst_n) begin
      limit_ms = LIMIT_RESET;
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        armed[k]    = 1'b0;
        answered[k] = 1'b0;
      end
      expected_results.delete();
      fail_count      = 0;
      match_count     = 0;
      good_read_count = 0;
    end else begin
      if (cfg_we)
        limit_ms = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        want = predict_rtt(in_ch.opcode, in_ch.entry_index[IDX_W-1:0],
                           {in_ch.tag_high, in_ch.tag_low}, in_ch.packet_length,
                           in_ch.now_ms);
        if (want.matched)
          match_count++;
        if (in_ch.opcode == OP_READ && want.rtt_valid)
          good_read_count++;
        expected_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(out_ch.match_index),
                          32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.matched !== want.matched)
            report_mismatch("matched", 32'(out_ch.matched), 32'(want.matched));
          if (out_ch.match_index !== want.match_index)
            report_mismatch("match_index", 32'(out_ch.match_index),
                            32'(want.match_index));
          if (out_ch.rtt_ms !== want.rtt_ms)
            report_mismatch("rtt_ms", out_ch.rtt_ms, want.rtt_ms);
          if (out_ch.rtt_valid !== want.rtt_valid)
            report_mismatch("rtt_valid", 32'(out_ch.rtt_valid), 32'(want.rtt_valid));
        end
      end
    end
    owed = expected_results.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives request items and limit writes into the tag matcher: a directed
// pass over arm, match, wrap, re-arm, short packet, read and limit corners,
// then random phases with sender gaps and receiver stalls. The monitor
// predicts and checks; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ttm_pkg::*;

  localparam logic [1:0] OP_IGNORED   = 2'd3;
  localparam int         PHASE_ITEMS  = 150;
  localparam int         POOL_SIZE    = 8;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned owed;
  int unsigned match_count;
  int unsigned good_read_count;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned sent_count;
  logic [LIMIT_W-1:0] limit_now;

  // stimulus bookkeeping, used only to aim responses and reads
  bit                was_armed [NUM_ENTRIES];
  logic [TAG_W-1:0]  armed_tag [NUM_ENTRIES];
  logic [TIME_W-1:0] armed_time[NUM_ENTRIES];
  logic [TAG_W-1:0]  tag_pool  [POOL_SIZE];

  ttm_in_if  in_ch();
  ttm_out_if out_ch();

  transaction_tag_rtt_matcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rtt_match_monitor i_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .owed            (owed),
    .match_count     (match_count),
    .good_read_count (good_read_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", owed);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] idx,
                           input logic [TAG_W-1:0] tag, input logic [9:0] len,
                           input logic [TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.opcode        = op;
    in_ch.entry_index   = idx;
    in_ch.tag_high      = tag[95:64];
    in_ch.tag_low       = tag[63:0];
    in_ch.packet_length = len;
    in_ch.now_ms        = now;
    in_ch.valid         = 1'b1;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    sent_count++;
    if (op == OP_ARM) begin
      was_armed[idx]  = 1'b1;
      armed_tag[idx]  = tag;
      armed_time[idx] = now;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (owed != 0)
      @(negedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    limit_now = value;
  endtask

  function automatic logic [7:0] pick_armed();
    logic [7:0] idx;
    for (int t = 0; t < 64; t++) begin
      idx = ($urandom_range(99) < 80) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
      if (was_armed[idx])
        return idx;
    end
    return 8'd0;
  endfunction

  function automatic logic [TAG_W-1:0] random_tag();
    return {$urandom, $urandom, $urandom};
  endfunction

  task automatic send_random_item(output bit counted);
    int unsigned pick;
    logic [7:0]  idx;
    logic [TAG_W-1:0] tag;
    logic [9:0]  len;
    logic [TIME_W-1:0] now;
    pick    = $urandom_range(99);
    len     = 10'($urandom_range(512));
    now     = $urandom;
    counted = 1'b1;
    if (pick < 33) begin
      idx = ($urandom_range(99) < 80) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
      tag = ($urandom_range(1)) ? tag_pool[$urandom_range(POOL_SIZE - 1)] : random_tag();
      send_item(OP_ARM, idx, tag, len, now);
    end else if (pick < 66) begin
      idx = pick_armed();
      if ($urandom_range(99) < 75)
        tag = armed_tag[idx];
      else if ($urandom_range(1))
        tag = tag_pool[$urandom_range(POOL_SIZE - 1)];
      else
        tag = random_tag();
      if ($urandom_range(99) < 80)
        now = armed_time[idx] + $urandom_range(2 * limit_now + 10);
      // mostly well-formed packets, some runts
      if ($urandom_range(99) < 15)
        len = 10'($urandom_range(MIN_PKT_LEN - 1));
      else
        len = 10'($urandom_range(512, MIN_PKT_LEN));
      send_item(OP_RESP, 8'($urandom), tag, len, now);
    end else if (pick < 94) begin
      send_item(OP_READ, pick_armed(), random_tag(), len, now);
    end else begin
      counted = 1'b0;
      send_item(OP_IGNORED, 8'($urandom), random_tag(), len, now);
    end
  endtask

  initial begin
    logic [TAG_W-1:0] tag_a;
    logic [TAG_W-1:0] ones;
    int unsigned phase_idle [4];
    int unsigned phase_stall[4];
    logic [LIMIT_W-1:0] phase_limit[4];
    int unsigned done;
    bit counted;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_ARM;
    in_ch.entry_index   = '0;
    in_ch.tag_high      = '0;
    in_ch.tag_low       = '0;
    in_ch.packet_length = '0;
    in_ch.now_ms        = '0;
    idle_pct            = 0;
    stall_pct           = 0;
    sent_count          = 0;
    limit_now           = LIMIT_RESET;
    for (int k = 0; k < POOL_SIZE; k++)
      tag_pool[k] = random_tag();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners, reset limit of 100 still in force
    tag_a = 96'h0123_4567_89ab_cdef_0011_2233;
    ones  = '1;
    send_item(OP_ARM,  8'd0,   tag_a, 10'd0,   32'd1000);
    send_item(OP_ARM,  8'd255, ones,  10'd512, 32'hffff_fff0);
    send_item(OP_ARM,  8'd5,   tag_a, 10'd20,  32'd2000);
    send_item(OP_READ, 8'd0,   ones,  10'd511, 32'hffff_ffff);  // armed, not answered
    send_item(OP_RESP, 8'd0,   tag_a, 10'd19,  32'd1050);       // runt packet
    send_item(OP_RESP, 8'd0,   tag_a, 10'd0,   32'd1050);
    send_item(OP_RESP, 8'd255, tag_a, 10'd20,  32'd1050);       // entry 0 wins
    send_item(OP_RESP, 8'd0,   tag_a, 10'd512, 32'd2099);       // then entry 5
    send_item(OP_RESP, 8'd0,   tag_a, 10'd100, 32'd3000);       // all answered
    send_item(OP_RESP, 8'd0,   ones,  10'd512, 32'h0000_000f);  // wrapping rtt
    send_item(OP_RESP, 8'd0,   '0,    10'd100, 32'd0);          // zero tag, never armed
    send_item(OP_READ, 8'd0,   '0,    10'd0,   32'd0);
    send_item(OP_READ, 8'd5,   '0,    10'd0,   32'd0);          // rtt 99 under 100
    send_item(OP_READ, 8'd255, '0,    10'd0,   32'd0);
    send_item(OP_ARM,  8'd0,   ones,  10'd0,   32'd7);          // re-arm clears answer
    send_item(OP_READ, 8'd0,   '0,    10'd0,   32'd0);
    send_item(OP_IGNORED, 8'hff, ones, 10'h3ff, 32'hffff_ffff);
    set_limit(16'd99);
    send_item(OP_READ, 8'd5,   '0,    10'd0,   32'd0);          // rtt at the limit
    set_limit(16'd0);
    send_item(OP_READ, 8'd255, '0,    10'd0,   32'd0);
    send_item(OP_READ, 8'd5,   '0,    10'd0,   32'd0);

    phase_idle  = '{0, 73, 0, 15};
    phase_stall = '{0, 0, 73, 15};
    phase_limit = '{16'hffff, 16'd1, 16'd300, 16'($urandom_range(65534, 2))};
    for (int p = 0; p < 4; p++) begin
      set_limit(phase_limit[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      done      = 0;
      while (done < PHASE_ITEMS) begin
        send_random_item(counted);
        if (counted)
          done++;
        // let the outstanding results drain once mid-run
        if (p == 1 && done == PHASE_ITEMS / 2 && counted)
          wait_drained();
      end
    end

    wait_drained();
    repeat (300) @(posedge clk);
    $display("sent %0d request items over limits 100, 99, 0, 65535, 1, 300 and one random",
             sent_count);
    $display("saw %0d tag matches and %0d reads inside the limit",
             match_count, good_read_count);
    if (fail_count == 0 && owed == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ttm_pkg.sv
rtl/core/ttm_ifs.sv
rtl/core/ttm_entry_store.sv
rtl/core/transaction_tag_rtt_matcher.sv
verif/rtt_match_monitor.sv
verif/testbench.sv
